// ----- sv/sorted_breakpoint_interpolator_unit_defines.svh -----
// Assertion macros for the sorted breakpoint interpolator.
// Included by the top level; define ASSERT_OFF to compile them out.
`ifndef SORTED_BREAKPOINT_INTERPOLATOR_UNIT_DEFINES_SVH
`define SORTED_BREAKPOINT_INTERPOLATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define SBI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbi assertion failed");

`define SBI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbi assertion failed");

`else

`define SBI_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SBI_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/sbi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the sorted breakpoint interpolator.
// No dependencies; used by every module of the block.
package sbi_pkg;

    localparam int COORD_W            = 32;
    localparam int DEFAULT_MAX_POINTS = 16;
    localparam int DIV_STEPS          = 32;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic                     start;
        logic [2*COORD_W-1:0]     dividend;
        logic [COORD_W-1:0]       divisor;
    } t_div_req;

endpackage

// ----- sv/sbi_store.sv -----
`timescale 1ns / 1ps
// Breakpoint memory: one write port and one registered read port.
// Depends on sbi_pkg for the point type.
module sbi_store
    import sbi_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  t_point                        i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    output t_point                        o_rd_data
);

    t_point r_mem [MAX_POINTS];
    t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/sbi_divider.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// The quotient must fit 32 bits. Depends on sbi_pkg.
module sbi_divider
    import sbi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_rem;
    logic [COORD_W-1:0]   r_quot;
    logic [COORD_W-1:0]   r_divisor;
    logic [COORD_W:0]     w_trial;
    logic [COORD_W:0]     w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quot[COORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= i_req.dividend[2*COORD_W-1:COORD_W];
            r_quot    <= i_req.dividend[COORD_W-1:0];
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[COORD_W-1:0] : w_trial[COORD_W-1:0];
            r_quot <= {r_quot[COORD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- sv/sorted_breakpoint_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Sorted breakpoint interpolator: a sequencer over the breakpoint memory
// and a serial divider. Depends on sbi_pkg, sbi_store, sbi_divider.
//
// One request at a time: a request is taken when start is high and busy is
// low, and its result appears on o_value_y/o_status for one cycle with
// o_valid high; the receiver cannot stall it. Clear, unused codes, an
// insert into a full table and a query on an empty table give their result
// in the cycle after the request is taken. An insert walks down from the
// top of the table, reading each larger entry and writing it one slot up,
// then writes the new point. A query walks up the entries, reading each in
// turn: below the first point it returns the first y, past the last of n
// points the last y, and in span i (entries i and i+1) it forms a 32x32
// multiply, starts the divider and waits for the bit-serial divide. The
// single memory read port bounds both walks.

`include "sorted_breakpoint_interpolator_unit_defines.svh"

module sorted_breakpoint_interpolator_unit
    import sbi_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_req_type,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic signed [COORD_W-1:0] i_coord_y,
    output logic                      o_valid,
    output logic signed [COORD_W-1:0] o_value_y,
    output logic [1:0]                o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_RD   = 3'd1;
    localparam logic [2:0] S_INS_CHK  = 3'd2;
    localparam logic [2:0] S_QRY_RD   = 3'd3;
    localparam logic [2:0] S_QRY_CHK  = 3'd4;
    localparam logic [2:0] S_MUL      = 3'd5;
    localparam logic [2:0] S_DIV      = 3'd6;
    localparam logic [2:0] S_DIV_WAIT = 3'd7;

    logic [2:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    logic                      r_valid, n_valid;
    logic signed [COORD_W-1:0] r_z, n_z;
    logic signed [COORD_W-1:0] r_y, n_y;
    t_point                    r_prev, n_prev;
    logic [COORD_W-1:0]        r_mag, n_mag;
    logic [COORD_W-1:0]        r_num, n_num;
    logic [COORD_W-1:0]        r_span, n_span;
    logic                      r_neg, n_neg;
    logic [2*COORD_W-1:0]      r_prod, n_prod;
    logic signed [COORD_W-1:0] r_value, n_value;
    logic [1:0]                r_status, n_status;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_point        w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_point        w_rd;
    t_point        w_new;
    logic [CW-1:0] w_idx_dec;

    logic signed [COORD_W:0] w_dy;
    logic [COORD_W:0]        w_ndy;
    logic [COORD_W-1:0]      w_num;
    logic [COORD_W-1:0]      w_span;

    t_div_req           w_div_req;
    logic               w_div_done;
    logic [COORD_W-1:0] w_quot;

    sbi_store #(
        .MAX_POINTS(MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    sbi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_new     = '{z: r_z, y: r_y};
    assign w_idx_dec = r_idx - 1'b1;
    assign w_dy      = {w_rd.y[COORD_W-1], w_rd.y} - {r_prev.y[COORD_W-1], r_prev.y};
    assign w_ndy     = ~w_dy + 1'b1;
    assign w_num     = r_z - r_prev.z;
    assign w_span    = w_rd.z - r_prev.z;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_valid  = 1'b0;
        n_z      = r_z;
        n_y      = r_y;
        n_prev   = r_prev;
        n_mag    = r_mag;
        n_num    = r_num;
        n_span   = r_span;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_value  = r_value;
        n_status = r_status;

        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[AW-1:0];
        w_wr_data = w_new;
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx[AW-1:0];

        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_prod;
        w_div_req.divisor  = r_span;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_z      = i_coord_z;
                    n_y      = i_coord_y;
                    n_value  = '0;
                    n_status = ST_OK;
                    case (i_req_type)
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        REQ_INSERT: begin
                            if (r_count >= CW'(MAX_POINTS)) begin
                                n_status = ST_FULL;
                                n_valid  = 1'b1;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        REQ_QUERY: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_valid  = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_QRY_RD;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx_dec[AW-1:0];
                    n_state   = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                w_wr_en = 1'b1;
                if (w_rd.z > r_z) begin
                    // shift the larger entry up one slot
                    w_wr_data = w_rd;
                    n_idx     = w_idx_dec;
                    n_state   = S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_QRY_RD: begin
                if (r_idx == r_count) begin
                    n_value = r_prev.y;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_QRY_CHK;
                end
            end
            S_QRY_CHK: begin
                if (r_z < w_rd.z) begin
                    if (r_idx == '0) begin
                        n_value = w_rd.y;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_neg   = w_dy[COORD_W];
                        n_mag   = w_dy[COORD_W] ? w_ndy[COORD_W-1:0] : w_dy[COORD_W-1:0];
                        n_num   = w_num;
                        n_span  = w_span;
                        n_state = S_MUL;
                    end
                end else begin
                    n_prev  = w_rd;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_QRY_RD;
                end
            end
            S_MUL: begin
                n_prod  = r_mag * r_num;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_div_req.start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_value = r_neg ? (r_prev.y - w_quot) : (r_prev.y + w_quot);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z      <= n_z;
        r_y      <= n_y;
        r_prev   <= n_prev;
        r_mag    <= n_mag;
        r_num    <= n_num;
        r_span   <= n_span;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_value_y = r_value;
    assign o_status  = r_status;

    `SBI_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE)
    `SBI_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_POINTS))
    `SBI_ASSERT_NXT(a_clear_done, i_clk, i_rst_n, start && !busy && i_req_type == REQ_CLEAR, r_valid && r_count == '0 && r_status == ST_OK)
    `SBI_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, w_div_done, r_state == S_DIV_WAIT)

endmodule
